[rtl/row_mean_color_defines.svh]
`ifndef ROW_MEAN_COLOR_DEFINES_SVH
`define ROW_MEAN_COLOR_DEFINES_SVH

// Concurrent check that is switched off while reset is held.
`define RMC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("row_mean_color check failed");

// Concurrent check that also holds across reset.
`define RMC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("row_mean_color reset check failed");

`endif

[rtl/rmc_pkg.sv]
package rmc_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 20;
    localparam int WIDTH_W = 13;
    localparam int STEPS   = PIX_W;
    localparam int STEP_W  = $clog2(STEPS);
    localparam int CHANS   = 3;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = {WIDTH_W{1'b1}};

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [WIDTH_W-1:0] t_count;
    typedef logic [PIX_W-1:0]   t_pix;

    // One finished row as handed from the accumulator to the divider.
    typedef struct packed {
        t_sum   [CHANS-1:0] sums;
        t_count             count;
    } t_row;

endpackage

[rtl/rmc_front.sv]
module rmc_front
    import rmc_pkg::*;
#(
    parameter logic [WIDTH_W-1:0] MAX_CLAMP = WIDTH_W'(4096)
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_valid,
    input  t_count i_cfg_data,
    input  logic   i_valid,
    input  t_pix   i_blue,
    input  t_pix   i_green,
    input  t_pix   i_red,
    input  logic   i_frame_start,
    input  logic   i_q_full,
    output logic   o_ready,
    output logic   o_push,
    output t_row   o_row
);

    t_count             r_row_width;
    t_sum   [CHANS-1:0] r_sums;
    t_count             r_col;
    t_sum   [CHANS-1:0] n_sums;
    t_count             n_col;
    t_count             active_w;
    t_count             count;
    logic               accept;
    logic               row_end;
    t_pix   [CHANS-1:0] pix;

    assign pix[CH_BLUE]  = i_blue;
    assign pix[CH_GREEN] = i_green;
    assign pix[CH_RED]   = i_red;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (r_row_width == '0) begin
            active_w = WIDTH_W'(1);
        end else if (r_row_width > MAX_CLAMP) begin
            active_w = MAX_CLAMP;
        end else begin
            active_w = r_row_width;
        end
    end

    always_comb begin
        for (int c = 0; c < CHANS; c++) begin
            n_sums[c] = (i_frame_start ? '0 : r_sums[c]) + SUM_W'(pix[c]);
        end
        count   = (i_frame_start ? '0 : r_col) + WIDTH_W'(1);
        row_end = (count >= active_w);
        n_col   = row_end ? '0 : count;
    end

    assign o_push       = accept && row_end;
    assign o_row.sums   = n_sums;
    assign o_row.count  = count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= WIDTH_RESET;
            r_sums      <= '0;
            r_col       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_row_width <= i_cfg_data;
            end
            if (accept) begin
                r_col <= n_col;
                for (int c = 0; c < CHANS; c++) begin
                    r_sums[c] <= row_end ? '0 : n_sums[c];
                end
            end
        end
    end

endmodule

[rtl/rmc_queue.sv]
module rmc_queue
    import rmc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_row i_row,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_row o_row
);

    t_row       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_row   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[rtl/rmc_back.sv]
module rmc_back
    import rmc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_row i_row,
    output logic o_pop,
    input  logic i_ready,
    output logic o_valid,
    output t_pix o_mean_blue,
    output t_pix o_mean_green,
    output t_pix o_mean_red
);

    logic                    r_busy;
    logic [STEP_W-1:0]       r_step;
    t_sum [CHANS-1:0]        r_rem;
    t_sum                    r_dsh;
    t_pix [CHANS-1:0]        r_quo;
    logic                    r_out_valid;
    t_pix [CHANS-1:0]        r_out;
    t_sum [CHANS-1:0]        n_rem;
    t_pix [CHANS-1:0]        n_quo;
    logic                    last;
    logic                    out_free;
    logic                    advance;

    // Restoring division: the quotient fits in eight bits as a row sum never
    // exceeds 255 times its pixel count; the divisor starts at count shifted
    // up by seven; one quotient bit per cycle, the last once output is free.
    always_comb begin
        for (int c = 0; c < CHANS; c++) begin
            if (r_rem[c] >= r_dsh) begin
                n_rem[c] = r_rem[c] - r_dsh;
                n_quo[c] = {r_quo[c][PIX_W-2:0], 1'b1};
            end else begin
                n_rem[c] = r_rem[c];
                n_quo[c] = {r_quo[c][PIX_W-2:0], 1'b0};
            end
        end
    end

    assign last     = (r_step == '0);
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_busy && (!last || out_free);
    assign o_pop    = !r_busy && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem <= i_row.sums;
            r_dsh <= SUM_W'({i_row.count, {(STEPS-1){1'b0}}});
            r_quo <= '0;
        end else if (advance) begin
            r_rem <= n_rem;
            r_dsh <= r_dsh >> 1;
            r_quo <= n_quo;
        end
        if (advance && last) begin
            r_out <= n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(STEPS - 1);
            end else if (advance) begin
                r_step <= r_step - STEP_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance && last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mean_blue  = r_out[CH_BLUE];
    assign o_mean_green = r_out[CH_GREEN];
    assign o_mean_red   = r_out[CH_RED];

endmodule

[rtl/row_mean_color.sv]
// Pixels are taken one per cycle while the row queue is not full; a pixel that
// closes a row yields its result through a queue write, a divider load, then 8
// divider steps, the last of which fills the output register once it is free.
// The divider takes a new row only when done, so short rows slow the input once
// the 2-entry row queue is full. Synchronous active-low reset restores row width
// 640, clears the sums, the column count, the queue and the output valid flag.
module row_mean_color
    import rmc_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [WIDTH_W-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_blue,
    input  logic [PIX_W-1:0]   i_green,
    input  logic [PIX_W-1:0]   i_red,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_mean_blue,
    output logic [PIX_W-1:0]   o_mean_green,
    output logic [PIX_W-1:0]   o_mean_red
);

    // A width above what the register can hold never clamps.
    localparam logic [WIDTH_W-1:0] MAX_CLAMP =
        (MAX_WIDTH > int'(WIDTH_LIMIT)) ? WIDTH_LIMIT : WIDTH_W'(MAX_WIDTH);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_row push_row;
    t_row head_row;

    assign o_cfg_ready = 1'b1;

    rmc_front #(
        .MAX_CLAMP (MAX_CLAMP)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_blue        (i_blue),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_row         (push_row)
    );

    rmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_row   (push_row),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_row   (head_row)
    );

    rmc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_row        (head_row),
        .o_pop        (pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_mean_blue  (o_mean_blue),
        .o_mean_green (o_mean_green),
        .o_mean_red   (o_mean_red)
    );

endmodule

[rtl/rmc_checker.sv]
`include "row_mean_color_defines.svh"

module rmc_checker
    import rmc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_ready,
    input logic             o_ready,
    input logic             o_valid,
    input logic [PIX_W-1:0] o_mean_blue,
    input logic [PIX_W-1:0] o_mean_green,
    input logic [PIX_W-1:0] o_mean_red
);

    // A result beat that is not taken stays offered.
    `RMC_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)

    // Its payload stays put until it is taken.
    `RMC_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_mean_blue) && $stable(o_mean_green) && $stable(o_mean_red))

    // Reset empties the result register.
    `RMC_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_valid)

    // Reset empties the row queue, so pixels are taken right away.
    `RMC_ASSERT_RST(a_rst_ready, i_clk, !i_rst_n |=> o_ready)

endmodule

bind row_mean_color rmc_checker u_rmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_ready      (i_ready),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .o_mean_blue  (o_mean_blue),
    .o_mean_green (o_mean_green),
    .o_mean_red   (o_mean_red)
);
